/* hdl/mpnn_pkg.sv */
// ============================================================================
// Marked point nearest neighbor package
// Shared constants and types for the marked point nearest neighbor search.
// ============================================================================
package mpnn_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int MAX_RESULTS    = 64;
    localparam int LIMIT_W        = 34;
    localparam int OUT_IDX_W      = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 34'd6553600000;

    typedef struct packed {
        logic ld;
        logic sh;
    } t_cell_ctrl;

endpackage

/* hdl/mpnn_cell.sv */
// ============================================================================
// Point cell
// Holds one point and its mark, loads it from the input side and passes it
// to the neighboring cell while the ring rotates.
// ============================================================================
module mpnn_cell #(
    parameter int COORD_BITS = mpnn_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  mpnn_pkg::t_cell_ctrl          i_ctrl,
    input  logic signed [COORD_BITS-1:0]  i_ld_x,
    input  logic signed [COORD_BITS-1:0]  i_ld_y,
    input  logic signed [COORD_BITS-1:0]  i_ld_z,
    input  logic                          i_ld_m,
    input  logic signed [COORD_BITS-1:0]  i_nb_x,
    input  logic signed [COORD_BITS-1:0]  i_nb_y,
    input  logic signed [COORD_BITS-1:0]  i_nb_z,
    input  logic                          i_nb_m,
    output logic signed [COORD_BITS-1:0]  o_x,
    output logic signed [COORD_BITS-1:0]  o_y,
    output logic signed [COORD_BITS-1:0]  o_z,
    output logic                          o_m
);

    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    logic signed [COORD_BITS-1:0] r_z;
    logic                         r_m;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld) begin
            r_x <= i_ld_x;
            r_y <= i_ld_y;
            r_z <= i_ld_z;
            r_m <= i_ld_m;
        end else if (i_ctrl.sh) begin
            r_x <= i_nb_x;
            r_y <= i_nb_y;
            r_z <= i_nb_z;
            r_m <= i_nb_m;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_m = r_m;

endmodule

/* hdl/mpnn_dist.sv */
// ============================================================================
// Squared distance unit
// Three stage pipeline: coordinate differences, squares, sum of squares.
// ============================================================================
module mpnn_dist #(
    parameter int COORD_BITS = mpnn_pkg::COORD_BITS_DEF,
    parameter int IDX_W      = 6,
    parameter int DIST_W     = 2 * COORD_BITS + 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [IDX_W-1:0]              i_idx,
    input  logic signed [COORD_BITS-1:0]  i_ax,
    input  logic signed [COORD_BITS-1:0]  i_ay,
    input  logic signed [COORD_BITS-1:0]  i_az,
    input  logic signed [COORD_BITS-1:0]  i_bx,
    input  logic signed [COORD_BITS-1:0]  i_by,
    input  logic signed [COORD_BITS-1:0]  i_bz,
    output logic                          o_valid,
    output logic [IDX_W-1:0]              o_idx,
    output logic [DIST_W-1:0]             o_dist
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = 2 * COORD_BITS + 1;

    logic signed [DW-1:0] n_dx, n_dy, n_dz;
    logic signed [DW-1:0] r_dx, r_dy, r_dz;
    logic signed [PW-1:0] n_px, n_py, n_pz;
    logic [SW-1:0]        r_sx, r_sy, r_sz;
    logic [DIST_W-1:0]    r_sum;
    logic [2:0]           r_v;
    logic [IDX_W-1:0]     r_i1, r_i2, r_i3;

    assign n_dx = DW'(i_ax) - DW'(i_bx);
    assign n_dy = DW'(i_ay) - DW'(i_by);
    assign n_dz = DW'(i_az) - DW'(i_bz);
    assign n_px = r_dx * r_dx;
    assign n_py = r_dy * r_dy;
    assign n_pz = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_dz  <= n_dz;
        r_i1  <= i_idx;
        r_sx  <= n_px[SW-1:0];
        r_sy  <= n_py[SW-1:0];
        r_sz  <= n_pz[SW-1:0];
        r_i2  <= r_i1;
        r_sum <= DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);
        r_i3  <= r_i2;
    end

    assign o_valid = r_v[2];
    assign o_idx   = r_i3;
    assign o_dist  = r_sum;

endmodule

/* hdl/marked_point_nearest_neighbour.sv */
// ============================================================================
// Marked point nearest neighbor search
// Points load into a ring of cells, one per item. The item that closes the
// set starts the search: the ring rotates past one squared distance unit
// once for every marked point, and one index pair is issued per marked
// point that has a neighbor inside the limit, up to MAX_RESULTS pairs.
// Items are accepted only while the block is idle; the item that closes the
// set makes the block busy for the search. For each marked point the search
// makes one full ring rotation and then waits for the distance pipeline;
// each unmarked point is skipped with one shift of the ring.
// Each pair is held until the next pair is decided or the search ends, and
// its strobe follows in the cycle after; results cannot be stalled. Reset clears
// the point count and control, and loads the limit register with its reset
// value; the point cells are not cleared.
// ============================================================================
module marked_point_nearest_neighbour #(
    parameter int MAX_POINTS = mpnn_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = mpnn_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_BITS-1:0]        i_coord_x,
    input  logic signed [COORD_BITS-1:0]        i_coord_y,
    input  logic signed [COORD_BITS-1:0]        i_coord_z,
    input  logic                                i_marked,
    input  logic                                i_last_point,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mpnn_pkg::LIMIT_W-1:0]        i_cfg_data,
    output logic                                o_result_valid,
    output logic [mpnn_pkg::OUT_IDX_W-1:0]      o_query_index,
    output logic [mpnn_pkg::OUT_IDX_W-1:0]      o_nearest_index,
    output logic                                o_last_pair
);

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIST_W = 2 * COORD_BITS + 2;
    localparam int CMP_W  = (DIST_W > mpnn_pkg::LIMIT_W) ? DIST_W : mpnn_pkg::LIMIT_W;
    localparam int RES_W  = $clog2(mpnn_pkg::MAX_RESULTS + 1);
    localparam int OW     = mpnn_pkg::OUT_IDX_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_QUERY = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    t_state                       r_state, n_state;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [IDX_W-1:0]             r_qi, n_qi;
    logic [IDX_W-1:0]             r_jidx, n_jidx;
    logic [IDX_W-1:0]             r_scan, n_scan;
    logic [1:0]                   r_drain, n_drain;
    logic                         r_found, n_found;
    logic [CMP_W-1:0]             r_best, n_best;
    logic [IDX_W-1:0]             r_best_idx, n_best_idx;
    logic                         r_pend_v, n_pend_v;
    logic [OW-1:0]                r_pend_q, n_pend_q;
    logic [OW-1:0]                r_pend_n, n_pend_n;
    logic [RES_W-1:0]             r_res_cnt, n_res_cnt;
    logic                         r_out_v, n_out_v;
    logic [OW-1:0]                r_out_q, n_out_q;
    logic [OW-1:0]                r_out_n, n_out_n;
    logic                         r_out_last, n_out_last;
    logic [mpnn_pkg::LIMIT_W-1:0] r_limit;
    logic signed [COORD_BITS-1:0] r_qx, r_qy, r_qz;

    logic signed [COORD_BITS-1:0] c_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] c_y [MAX_POINTS];
    logic signed [COORD_BITS-1:0] c_z [MAX_POINTS];
    logic                         c_m [MAX_POINTS];

    logic                         accept;
    logic                         shift;
    logic                         last_q;
    logic                         issue;
    logic                         d_v;
    logic [IDX_W-1:0]             d_idx;
    logic [DIST_W-1:0]            d_dist;
    logic [CMP_W-1:0]             d_ext;
    logic                         take;
    logic                         scan_end;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign last_q   = (CNT_W'(r_qi) + CNT_W'(1)) == r_cnt;
    assign scan_end = (r_scan == IDX_W'(MAX_POINTS - 1));
    assign issue    = (r_state == S_SCAN) && (CNT_W'(r_jidx) < r_cnt) && (r_jidx != r_qi);

    generate
        for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
            localparam int NB = (k + 1) % MAX_POINTS;
            mpnn_pkg::t_cell_ctrl ctrl;
            assign ctrl.ld = accept && (r_cnt == CNT_W'(k));
            assign ctrl.sh = shift;
            mpnn_cell #(
                .COORD_BITS (COORD_BITS)
            ) u_cell (
                .i_clk  (i_clk),
                .i_ctrl (ctrl),
                .i_ld_x (i_coord_x),
                .i_ld_y (i_coord_y),
                .i_ld_z (i_coord_z),
                .i_ld_m (i_marked),
                .i_nb_x (c_x[NB]),
                .i_nb_y (c_y[NB]),
                .i_nb_z (c_z[NB]),
                .i_nb_m (c_m[NB]),
                .o_x    (c_x[k]),
                .o_y    (c_y[k]),
                .o_z    (c_z[k]),
                .o_m    (c_m[k])
            );
        end
    endgenerate

    mpnn_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W),
        .DIST_W     (DIST_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (issue),
        .i_idx   (r_jidx),
        .i_ax    (r_qx),
        .i_ay    (r_qy),
        .i_az    (r_qz),
        .i_bx    (c_x[0]),
        .i_by    (c_y[0]),
        .i_bz    (c_z[0]),
        .o_valid (d_v),
        .o_idx   (d_idx),
        .o_dist  (d_dist)
    );

    assign d_ext = CMP_W'(d_dist);
    assign take  = d_v && (d_ext < CMP_W'(r_limit)) &&
                   (!r_found || (d_ext < r_best) || ((d_ext == r_best) && (d_idx < r_best_idx)));

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_qi       = r_qi;
        n_jidx     = r_jidx;
        n_scan     = r_scan;
        n_drain    = r_drain;
        n_found    = r_found;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_pend_v   = r_pend_v;
        n_pend_q   = r_pend_q;
        n_pend_n   = r_pend_n;
        n_res_cnt  = r_res_cnt;
        n_out_v    = 1'b0;
        n_out_q    = r_out_q;
        n_out_n    = r_out_n;
        n_out_last = 1'b0;
        shift      = 1'b0;

        if (take) begin
            n_found    = 1'b1;
            n_best     = d_ext;
            n_best_idx = d_idx;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_cnt != CNT_W'(MAX_POINTS)) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    if (i_last_point) begin
                        n_qi    = '0;
                        n_state = S_QUERY;
                    end
                end
            end
            S_QUERY: begin
                if (c_m[0]) begin
                    n_found = 1'b0;
                    n_jidx  = r_qi;
                    n_scan  = '0;
                    n_state = S_SCAN;
                end else begin
                    shift   = 1'b1;
                    n_qi    = r_qi + IDX_W'(1);
                    n_state = last_q ? S_FLUSH : S_QUERY;
                end
            end
            S_SCAN: begin
                shift  = 1'b1;
                n_jidx = (r_jidx == IDX_W'(MAX_POINTS - 1)) ? '0 : r_jidx + IDX_W'(1);
                n_scan = r_scan + IDX_W'(1);
                if (scan_end) begin
                    n_drain = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_drain = r_drain + 2'd1;
                if (r_drain == 2'd3) begin
                    shift = 1'b1;
                    n_qi  = r_qi + IDX_W'(1);
                    if (r_found && (r_res_cnt < RES_W'(mpnn_pkg::MAX_RESULTS))) begin
                        if (r_pend_v) begin
                            n_out_v = 1'b1;
                            n_out_q = r_pend_q;
                            n_out_n = r_pend_n;
                        end
                        n_pend_v  = 1'b1;
                        n_pend_q  = OW'(r_qi);
                        n_pend_n  = OW'(r_best_idx);
                        n_res_cnt = r_res_cnt + RES_W'(1);
                    end
                    n_state = last_q ? S_FLUSH : S_QUERY;
                end
            end
            S_FLUSH: begin
                if (r_pend_v) begin
                    n_out_v    = 1'b1;
                    n_out_q    = r_pend_q;
                    n_out_n    = r_pend_n;
                    n_out_last = 1'b1;
                end
                n_pend_v  = 1'b0;
                n_cnt     = '0;
                n_qi      = '0;
                n_res_cnt = '0;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_qi      <= '0;
            r_drain   <= '0;
            r_found   <= 1'b0;
            r_pend_v  <= 1'b0;
            r_res_cnt <= '0;
            r_out_v   <= 1'b0;
            r_limit   <= mpnn_pkg::LIMIT_RESET;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_qi      <= n_qi;
            r_drain   <= n_drain;
            r_found   <= n_found;
            r_pend_v  <= n_pend_v;
            r_res_cnt <= n_res_cnt;
            r_out_v   <= n_out_v;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_jidx     <= n_jidx;
        r_scan     <= n_scan;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_pend_q   <= n_pend_q;
        r_pend_n   <= n_pend_n;
        r_out_q    <= n_out_q;
        r_out_n    <= n_out_n;
        r_out_last <= n_out_last;
        if ((r_state == S_QUERY) && c_m[0]) begin
            r_qx <= c_x[0];
            r_qy <= c_y[0];
            r_qz <= c_z[0];
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_result_valid  = r_out_v;
    assign o_query_index   = r_out_q;
    assign o_nearest_index = r_out_n;
    assign o_last_pair     = r_out_v && r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS))
        else $error("Point count exceeds the store capacity.");

    a_close_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_point) |=> busy)
        else $error("Closing item did not start the search.");

    a_result_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("Result item issued outside a search.");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_pair |-> (!busy && r_cnt == '0))
        else $error("Final pair issued before the search finished.");

    a_issue_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (r_state == S_SCAN && CNT_W'(r_jidx) < r_cnt))
        else $error("Distance issued for a point outside the set.");

endmodule
